// ----- rtl/huffman_code_bit_packer_macros.svh -----
// Assertion helpers for the bit packer. Every check is sampled on the rising
// edge of i_clk and is switched off while i_rst_n is low.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define HCBP_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// The condition holds in the cycle after the trigger.
`define HCBP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/hcbp_pkg.sv -----
`default_nettype none
package hcbp_pkg;

    localparam int SYM_W       = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int VAL_IN_W    = 32;
    localparam int LEN_W       = 6;
    localparam int VBITS_W     = 7;
    localparam int TOTAL_W     = 48;
    localparam int OP_W        = 2;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_LOAD   = 2'd0;
    localparam t_op OP_ENCODE = 2'd1;
    localparam t_op OP_FLUSH  = 2'd2;

    // Result of the table lookup for one beat, handed to the packer.
    typedef struct packed {
        t_op                 op;
        logic [LEN_W-1:0]    len;
        logic [VAL_IN_W-1:0] val;
    } t_lookup;

endpackage
`default_nettype wire

// ----- rtl/huffman_code_bit_packer.sv -----
// Huffman encoder back end. Each input beat is a load (op 0: writes code value
// and length for table entry symbol), an encode (op 1: appends the code of byte
// symbol to the output stream, most significant bit first) or a flush (op 2:
// emits the partial last word with tlast set, then starts a new stream). Full
// words leave with valid_bits equal to WORD_BITS; a code crossing a word
// boundary finishes the current word and starts the next one at its top bit.
// total_bits counts the code bits of the stream and saturates. Entries that
// were never loaded have length zero and add nothing; op 3 is ignored. The
// block takes one beat per clock cycle as long as the output drains. Each beat
// goes through the registered read of the 256-entry code table and then the
// packing shifter feeding the output register. The table's entries come out
// of reset unloaded, so no clearing pass is needed.
`default_nettype none
`include "huffman_code_bit_packer_macros.svh"
module huffman_code_bit_packer #(
    parameter int MAX_CODE_BITS = 32,
    parameter int WORD_BITS     = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     s_axis_tvalid,
    output      logic                     s_axis_tready,
    // symbol [7:0], code_value [39:8], code_length [45:40], zero pad [47:46]
    input  wire logic [47:0]              s_axis_tdata,
    // op [1:0]
    input  wire logic [1:0]               s_axis_tuser,

    output      logic                     m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // packed_word [WORD_BITS-1:0], valid_bits (7 bits), total_bits (48 bits),
    // zero pad up to a whole byte
    output      logic [((WORD_BITS + 55 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // last: high on the flush beat that ends a stream
    output      logic                     m_axis_tlast
);

    localparam int OUT_BITS = WORD_BITS + hcbp_pkg::VBITS_W + hcbp_pkg::TOTAL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic                          in_accept;
    logic                          stage_busy;
    logic                          advance;
    hcbp_pkg::t_lookup             lookup;
    logic [WORD_BITS-1:0]          out_word;
    logic [hcbp_pkg::VBITS_W-1:0]  out_vbits;
    logic [hcbp_pkg::TOTAL_W-1:0]  out_total;

    // The lookup stage frees up whenever the packer can take its beat, so a
    // waiting result never blocks the input as long as the output drains.
    assign s_axis_tready = !stage_busy || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    hcbp_code_table #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .WORD_BITS     (WORD_BITS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_advance     (advance),
        .i_op          (s_axis_tuser),
        .i_symbol      (s_axis_tdata[7:0]),
        .i_code_value  (s_axis_tdata[39:8]),
        .i_code_length (s_axis_tdata[45:40]),
        .o_busy        (stage_busy),
        .o_lookup      (lookup)
    );

    hcbp_packer #(
        .WORD_BITS    (WORD_BITS)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (stage_busy),
        .i_lookup     (lookup),
        .i_out_ready  (m_axis_tready),
        .o_advance    (advance),
        .o_out_valid  (m_axis_tvalid),
        .o_word       (out_word),
        .o_valid_bits (out_vbits),
        .o_total_bits (out_total),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({out_total, out_vbits, out_word});

    // A full word always carries every bit position.
    `HCBP_ASSERT_SAME(a_full_word_count, m_axis_tvalid && !m_axis_tlast, out_vbits == hcbp_pkg::VBITS_W'(WORD_BITS), "full word without WORD_BITS valid bits")

    // The partial word of a flush can never be full.
    `HCBP_ASSERT_SAME(a_flush_partial, m_axis_tvalid && m_axis_tlast, out_vbits < hcbp_pkg::VBITS_W'(WORD_BITS), "flush word reports a full fill")

    // A draining output always lets the input side move.
    `HCBP_ASSERT_SAME(a_ready_on_drain, m_axis_tready, s_axis_tready, "input stalled while output drains")

    // An accepted beat leaves the lookup stage occupied on the next cycle.
    `HCBP_ASSERT_NEXT(a_stage_fill, in_accept, stage_busy, "accepted beat did not reach the lookup stage")

endmodule
`default_nettype wire

// ----- rtl/hcbp_code_table.sv -----
`default_nettype none
module hcbp_code_table #(
    parameter int MAX_CODE_BITS = 32,
    parameter int WORD_BITS     = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_advance,
    input  wire hcbp_pkg::t_op                 i_op,
    input  wire logic [hcbp_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic [hcbp_pkg::VAL_IN_W-1:0] i_code_value,
    input  wire logic [hcbp_pkg::LEN_W-1:0]    i_code_length,
    output      logic                          o_busy,
    output      hcbp_pkg::t_lookup             o_lookup
);

    localparam int CLAMP = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
    localparam int VAL_W = (CLAMP < hcbp_pkg::VAL_IN_W) ? CLAMP : hcbp_pkg::VAL_IN_W;

    logic [VAL_W-1:0]                r_mem_val [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::LEN_W-1:0]      r_mem_len [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::TABLE_DEPTH-1:0] r_entry_valid;

    logic                       r_busy;
    hcbp_pkg::t_op              r_op;
    logic [VAL_W-1:0]           r_rd_val;
    logic [hcbp_pkg::LEN_W-1:0] r_rd_len;
    logic                       r_rd_ok;

    logic [hcbp_pkg::LEN_W-1:0] len_clamped;
    logic [VAL_W-1:0]           val_mask;
    logic                       is_load;

    // Lengths above the clamp are cut down, and the value keeps only its low
    // (clamped length) bits.
    always_comb begin
        len_clamped = (i_code_length > hcbp_pkg::LEN_W'(CLAMP))
                    ? hcbp_pkg::LEN_W'(CLAMP) : i_code_length;
        val_mask    = (len_clamped >= hcbp_pkg::LEN_W'(VAL_W))
                    ? {VAL_W{1'b1}} : ~({VAL_W{1'b1}} << len_clamped);
        is_load     = i_accept && (i_op == hcbp_pkg::OP_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_busy        <= 1'b0;
        end else begin
            if (is_load) begin
                r_entry_valid[i_symbol] <= 1'b1;
            end
            if (i_accept) begin
                r_busy <= 1'b1;
            end else if (i_advance) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Table storage and registered read. A read sees every load accepted on
    // an earlier edge, which keeps the stream order intact.
    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_mem_val[i_symbol] <= i_code_value[VAL_W-1:0] & val_mask;
            r_mem_len[i_symbol] <= len_clamped;
        end
        if (i_accept) begin
            r_op     <= i_op;
            r_rd_val <= r_mem_val[i_symbol];
            r_rd_len <= r_mem_len[i_symbol];
            r_rd_ok  <= r_entry_valid[i_symbol];
        end
    end

    always_comb begin
        o_busy       = r_busy;
        o_lookup.op  = r_op;
        o_lookup.len = r_rd_ok ? r_rd_len : '0;
        o_lookup.val = r_rd_ok ? hcbp_pkg::VAL_IN_W'(r_rd_val) : '0;
    end

endmodule
`default_nettype wire

// ----- rtl/hcbp_packer.sv -----
`default_nettype none
module hcbp_packer #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire hcbp_pkg::t_lookup             i_lookup,
    input  wire logic                          i_out_ready,
    output      logic                          o_advance,
    output      logic                          o_out_valid,
    output      logic [WORD_BITS-1:0]          o_word,
    output      logic [hcbp_pkg::VBITS_W-1:0]  o_valid_bits,
    output      logic [hcbp_pkg::TOTAL_W-1:0]  o_total_bits,
    output      logic                          o_last
);

    localparam int DW     = 2 * WORD_BITS;
    localparam int FILL_W = $clog2(WORD_BITS);
    localparam int SUM_W  = $clog2(DW);
    localparam int SH_W   = $clog2(DW) + 1;

    logic [WORD_BITS-1:0]         r_acc,   n_acc;
    logic [FILL_W-1:0]            r_fill,  n_fill;
    logic [hcbp_pkg::TOTAL_W-1:0] r_total, n_total;

    logic                          r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0]          r_word,  n_word;
    logic [hcbp_pkg::VBITS_W-1:0]  r_vbits, n_vbits;
    logic [hcbp_pkg::TOTAL_W-1:0]  r_otot,  n_otot;
    logic                          r_last,  n_last;

    logic                         advance;
    logic                         take;
    logic [SUM_W-1:0]             sum;
    logic [SH_W-1:0]              shift_amt;
    logic [DW-1:0]                merged;
    logic [hcbp_pkg::TOTAL_W:0]   total_sum;
    logic [hcbp_pkg::TOTAL_W-1:0] total_sat;

    always_comb begin
        advance   = !r_out_valid || i_out_ready;
        take      = i_in_valid && advance;
        sum       = SUM_W'(r_fill) + SUM_W'(i_lookup.len);
        shift_amt = SH_W'(DW) - SH_W'(sum);
        // The code is placed right below the bits already held; the upper half
        // is the current word and the lower half carries the split-off tail.
        merged    = {r_acc, {WORD_BITS{1'b0}}} | (DW'(i_lookup.val) << shift_amt);
        total_sum = {1'b0, r_total} + (hcbp_pkg::TOTAL_W + 1)'(i_lookup.len);
        total_sat = total_sum[hcbp_pkg::TOTAL_W] ? {hcbp_pkg::TOTAL_W{1'b1}}
                                                 : total_sum[hcbp_pkg::TOTAL_W-1:0];

        n_acc       = r_acc;
        n_fill      = r_fill;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_word      = r_word;
        n_vbits     = r_vbits;
        n_otot      = r_otot;
        n_last      = r_last;

        if (take) begin
            case (i_lookup.op)
                hcbp_pkg::OP_ENCODE: begin
                    if (i_lookup.len != '0) begin
                        n_total = total_sat;
                        if (sum >= SUM_W'(WORD_BITS)) begin
                            n_acc       = merged[WORD_BITS-1:0];
                            n_fill      = FILL_W'(sum - SUM_W'(WORD_BITS));
                            n_out_valid = 1'b1;
                            n_word      = merged[DW-1:WORD_BITS];
                            n_vbits     = hcbp_pkg::VBITS_W'(WORD_BITS);
                            n_otot      = total_sat;
                            n_last      = 1'b0;
                        end else begin
                            n_acc  = merged[DW-1:WORD_BITS];
                            n_fill = FILL_W'(sum);
                        end
                    end
                end
                hcbp_pkg::OP_FLUSH: begin
                    n_out_valid = 1'b1;
                    n_word      = r_acc;
                    n_vbits     = hcbp_pkg::VBITS_W'(r_fill);
                    n_otot      = r_total;
                    n_last      = 1'b1;
                    n_acc       = '0;
                    n_fill      = '0;
                    n_total     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_vbits <= n_vbits;
        r_otot  <= n_otot;
        r_last  <= n_last;
    end

    always_comb begin
        o_advance    = advance;
        o_out_valid  = r_out_valid;
        o_word       = r_word;
        o_valid_bits = r_vbits;
        o_total_bits = r_otot;
        o_last       = r_last;
    end

endmodule
`default_nettype wire
